@@ design/modem_reply_line_classifier_assert.svh @@
// Assertion macros used by the modem reply line classifier checker
`ifndef MODEM_REPLY_LINE_CLASSIFIER_ASSERT_SVH
`define MODEM_REPLY_LINE_CLASSIFIER_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define MRLC_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("modem reply line classifier check failed");

// Next-cycle implication that also holds while reset is applied
`define MRLC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("modem reply line classifier check failed");

`endif

@@ design/mrlc_pkg.sv @@
// Package: constants, types and keyword tables of the modem reply line classifier
`timescale 1ns / 1ps

package mrlc_pkg;

    localparam int LINE_MAX   = 256;
    localparam int LCNT_W     = $clog2(LINE_MAX);
    localparam int NUM_KEYS   = 8;
    localparam int KEY_MAX    = 17;
    localparam int PROG_W     = $clog2(KEY_MAX);
    localparam int PREFIX_LEN = 27;
    localparam int PFX_IDX_W  = $clog2(PREFIX_LEN);

    localparam logic [7:0] CH_NL = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    // keyword slots
    localparam int K_WIFI    = 0;
    localparam int K_DISC    = 1;
    localparam int K_CONN    = 2;
    localparam int K_GOTIP   = 3;
    localparam int K_ALREADY = 4;
    localparam int K_CONNECT = 5;
    localparam int K_CLOSED  = 6;
    localparam int K_SENDOK  = 7;

    // strings are right-justified: first character in the highest used byte
    localparam logic [KEY_MAX*8-1:0] KEY_TEXT [NUM_KEYS] = '{
        (KEY_MAX*8)'("WIFI "),
        (KEY_MAX*8)'("DISCONNECTED"),
        (KEY_MAX*8)'("CONNECTED"),
        (KEY_MAX*8)'("GOT IP"),
        (KEY_MAX*8)'("ALREADY CONNECTED"),
        (KEY_MAX*8)'("CONNECT"),
        (KEY_MAX*8)'("CLOSED"),
        (KEY_MAX*8)'("SEND OK")
    };
    localparam int KEY_LEN [NUM_KEYS] = '{5, 12, 9, 6, 17, 7, 6, 7};

    localparam logic [PREFIX_LEN*8-1:0] PREFIX_TEXT [2] = '{
        "+IPD,19:verification:passed",
        "+IPD,19:verification:failed"
    };

    typedef enum logic [2:0] {
        LS_DISCONNECTED = 3'd0,
        LS_JOINED       = 3'd1,
        LS_HAS_ADDR     = 3'd2,
        LS_SERVER       = 3'd3,
        LS_DATA_SENT    = 3'd4
    } link_state_t;

    typedef enum logic [1:0] {
        VD_NONE   = 2'd0,
        VD_PASSED = 2'd1,
        VD_FAILED = 2'd2
    } verdict_t;

    typedef struct packed {
        logic step;   // one line character consumed
        logic clr;    // restart the line
    } scan_ctl_t;

    function automatic logic [7:0] key_char(input int k, input int i);
        key_char = KEY_TEXT[k][(KEY_LEN[k]-1-i)*8 +: 8];
    endfunction

    function automatic logic [7:0] prefix_char(input int j, input logic [PFX_IDX_W-1:0] i);
        prefix_char = PREFIX_TEXT[j][(PREFIX_LEN-1-int'(i))*8 +: 8];
    endfunction

    // Bit n set when the first n-1 keyword characters end the first p
    // characters of the keyword, so a match of character n extends to length n.
    function automatic logic [KEY_MAX:0] key_border(input int k, input int p);
        logic [KEY_MAX:0] m;
        logic ok;
        m = '0;
        for (int n = 1; n <= KEY_MAX; n++) begin
            ok = (n <= p + 1) && (n <= KEY_LEN[k]);
            for (int i = 0; i < KEY_MAX - 1; i++) begin
                if (ok && (i < n - 1)) begin
                    if (key_char(k, i) != key_char(k, p + 1 - n + i)) begin
                        ok = 1'b0;
                    end
                end
            end
            m[n] = ok;
        end
        return m;
    endfunction

endpackage

@@ design/mrlc_kw_bank.sv @@
// Eight parallel streaming keyword matchers with per-line seen flags
`timescale 1ns / 1ps

module mrlc_kw_bank (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mrlc_pkg::scan_ctl_t           ctl,
    input  logic [7:0]                    rx_char,
    output logic [mrlc_pkg::NUM_KEYS-1:0] seen
);

    logic [mrlc_pkg::PROG_W-1:0]   prog_reg  [mrlc_pkg::NUM_KEYS];
    logic [mrlc_pkg::PROG_W-1:0]   prog_next [mrlc_pkg::NUM_KEYS];
    logic [mrlc_pkg::NUM_KEYS-1:0] seen_reg;
    logic [mrlc_pkg::NUM_KEYS-1:0] hit;

    always_comb begin
        logic [mrlc_pkg::KEY_MAX:0] eq;
        logic [mrlc_pkg::KEY_MAX:0] mask;
        logic [mrlc_pkg::KEY_MAX:0] cand;
        for (int k = 0; k < mrlc_pkg::NUM_KEYS; k++) begin
            eq = '0;
            for (int n = 1; n <= mrlc_pkg::KEY_MAX; n++) begin
                if (n <= mrlc_pkg::KEY_LEN[k]) begin
                    eq[n] = (rx_char == mrlc_pkg::key_char(k, n - 1));
                end
            end
            // progress never exceeds keyword length - 1
            mask = '0;
            for (int p = 0; p < mrlc_pkg::KEY_MAX; p++) begin
                if (prog_reg[k] == mrlc_pkg::PROG_W'(p)) begin
                    mask = mrlc_pkg::key_border(k, p);
                end
            end
            cand   = mask & eq;
            hit[k] = cand[mrlc_pkg::KEY_LEN[k]];
            // longest partial match kept below the full length
            prog_next[k] = '0;
            for (int n = 1; n <= mrlc_pkg::KEY_MAX; n++) begin
                if (cand[n] && (n < mrlc_pkg::KEY_LEN[k])) begin
                    prog_next[k] = mrlc_pkg::PROG_W'(n);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clr) begin
            seen_reg <= '0;
            for (int k = 0; k < mrlc_pkg::NUM_KEYS; k++) begin
                prog_reg[k] <= '0;
            end
        end else if (ctl.step) begin
            seen_reg <= seen_reg | hit;
            for (int k = 0; k < mrlc_pkg::NUM_KEYS; k++) begin
                prog_reg[k] <= prog_next[k];
            end
        end
    end

    assign seen = seen_reg;

endmodule

@@ design/modem_reply_line_classifier.sv @@
// Top level: modem reply line classifier
// Usage:
//   Slave channel s_*: one received modem byte per transfer in s_tdata[7:0].
//   Carriage returns are dropped; other bytes except newline extend the line.
//   Master channel m_*: one transfer per newline carrying the link state after
//   the line, a state-changed flag, the verification verdict and the line
//   length (low 8 bits of the count since the last wrap).
//   A newline is held in the input register, then its result is registered in the result register that drives m_*.
//   Throughput: one byte per cycle, unless a newline waits on a stalled receiver;
//   all keyword matchers and both prefix checkers step together on the registered byte.
//   Lines wrap to empty after LINE_MAX kept characters.
//   Reset (aresetn low, synchronous) empties both registers, sets the link
//   state to disconnected and clears the line.
//   When the receiver stalls, the held result stays on m_* and bytes other
//   than newline keep flowing; a newline waits in the input register, with
//   s_tready low, until the result register frees.
`timescale 1ns / 1ps

module modem_reply_line_classifier (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [2:0] link_state, [3] state_changed,
                                   // [5:4] verdict, [13:6] line_length, [15:14] zero
);

    logic                          in_valid_reg;
    logic [7:0]                    in_byte_reg;
    logic                          m_tvalid_reg;
    logic [15:0]                   m_tdata_reg;
    logic [15:0]                   m_tdata_next;
    logic [mrlc_pkg::LCNT_W-1:0]   cnt_reg;
    logic [mrlc_pkg::LCNT_W-1:0]   cnt_next;
    logic [mrlc_pkg::LCNT_W:0]     cnt_inc;
    logic [1:0]                    alive_reg;
    logic [1:0]                    alive_next;
    mrlc_pkg::link_state_t         state_reg;
    mrlc_pkg::link_state_t         state_next;
    mrlc_pkg::verdict_t            verdict;
    mrlc_pkg::scan_ctl_t           ctl;
    logic [mrlc_pkg::NUM_KEYS-1:0] seen;
    logic                          is_nl;
    logic                          is_cr;
    logic                          out_free;
    logic                          fire;
    logic                          wrap;
    logic                          in_prefix;

    assign is_nl    = (in_byte_reg == mrlc_pkg::CH_NL);
    assign is_cr    = (in_byte_reg == mrlc_pkg::CH_CR);
    assign out_free = !m_tvalid_reg || m_tready;
    assign fire     = in_valid_reg && (!is_nl || out_free);
    assign s_tready = !in_valid_reg || fire;

    assign cnt_inc   = {1'b0, cnt_reg} + 1'b1;
    assign wrap      = (cnt_inc == (mrlc_pkg::LCNT_W+1)'(mrlc_pkg::LINE_MAX));
    assign in_prefix = (cnt_reg < mrlc_pkg::LCNT_W'(mrlc_pkg::PREFIX_LEN));

    assign ctl.step = fire && !is_nl && !is_cr;
    assign ctl.clr  = (fire && is_nl) || (ctl.step && wrap);

    mrlc_kw_bank u_kw_bank (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .rx_char (in_byte_reg),
        .seen    (seen)
    );

    always_comb begin
        alive_next = alive_reg;
        if (ctl.clr) begin
            alive_next = 2'b11;
        end else if (ctl.step && in_prefix) begin
            for (int j = 0; j < 2; j++) begin
                if (in_byte_reg != mrlc_pkg::prefix_char(j,
                        cnt_reg[mrlc_pkg::PFX_IDX_W-1:0])) begin
                    alive_next[j] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        if (ctl.clr) begin
            cnt_next = '0;
        end else if (ctl.step) begin
            cnt_next = cnt_inc[mrlc_pkg::LCNT_W-1:0];
        end else begin
            cnt_next = cnt_reg;
        end
    end

    // first matching rule wins
    always_comb begin
        state_next = state_reg;
        if (seen[mrlc_pkg::K_WIFI]) begin
            if (seen[mrlc_pkg::K_DISC]) begin
                state_next = mrlc_pkg::LS_DISCONNECTED;
            end else if (seen[mrlc_pkg::K_CONN]) begin
                state_next = mrlc_pkg::LS_JOINED;
            end else if (seen[mrlc_pkg::K_GOTIP]) begin
                state_next = mrlc_pkg::LS_HAS_ADDR;
            end
        end else if (seen[mrlc_pkg::K_ALREADY] || seen[mrlc_pkg::K_CONNECT]) begin
            state_next = mrlc_pkg::LS_SERVER;
        end else if (seen[mrlc_pkg::K_CLOSED]) begin
            state_next = mrlc_pkg::LS_HAS_ADDR;
        end else if (seen[mrlc_pkg::K_SENDOK]) begin
            state_next = mrlc_pkg::LS_DATA_SENT;
        end

        verdict = mrlc_pkg::VD_NONE;
        if (!in_prefix) begin
            if (alive_reg[0]) begin
                verdict = mrlc_pkg::VD_PASSED;
            end else if (alive_reg[1]) begin
                verdict = mrlc_pkg::VD_FAILED;
            end
        end

        m_tdata_next = {2'b00, 8'(cnt_reg), verdict, (state_next != state_reg), state_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= '0;
            alive_reg    <= 2'b11;
            state_reg    <= mrlc_pkg::LS_DISCONNECTED;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end

            if (fire && is_nl) begin
                m_tvalid_reg <= 1'b1;
                state_reg    <= state_next;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            cnt_reg   <= cnt_next;
            alive_reg <= alive_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (fire && is_nl) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ design/mrlc_checker.sv @@
// Port-level checker for the modem reply line classifier, with its bind
`timescale 1ns / 1ps
`include "modem_reply_line_classifier_assert.svh"

module mrlc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // a stalled result holds
    `MRLC_ASSERT(a_hold, m_tvalid && !m_tready, ##1 (m_tvalid && $stable(m_tdata)))
    // link state and verdict stay in their legal ranges, padding is zero
    `MRLC_ASSERT(a_state_range, m_tvalid, m_tdata[2:0] <= mrlc_pkg::LS_DATA_SENT)
    `MRLC_ASSERT(a_verdict_range, m_tvalid, (m_tdata[5:4] <= mrlc_pkg::VD_FAILED) && (m_tdata[15:14] == 2'd0))
    // reset empties the result register
    `MRLC_ASSERT_NEXT(a_reset_empty, !aresetn, !m_tvalid)
    // a byte other than newline never produces a result from the input register
    `MRLC_ASSERT(a_no_spurious, s_tvalid && s_tready && (s_tdata != mrlc_pkg::CH_NL) && !m_tvalid,
                 ##2 !(m_tvalid && !$past(m_tvalid)) || $past(s_tvalid && s_tready))

endmodule

bind modem_reply_line_classifier mrlc_checker u_mrlc_checker (.*);

@@ test/tb_modem_reply_line_classifier.sv @@
`timescale 1ns / 1ps
// Testbench: modem reply line classifier, byte stream checked against a line predictor
module tb_modem_reply_line_classifier;
    import mrlc_pkg::*;

    localparam int RUN_LIMIT    = 400000;
    localparam int PFX_CHARS    = 27;
    localparam int RANDOM_BYTES = 1000;

    typedef struct {
        link_state_t state;
        logic        changed;
        verdict_t    verdict;
        logic [7:0]  length;
    } line_report_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    modem_reply_line_classifier dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    string kw_text [NUM_KEYS] = '{"WIFI ", "DISCONNECTED", "CONNECTED", "GOT IP",
                                  "ALREADY CONNECTED", "CONNECT", "CLOSED", "SEND OK"};
    string pfx_text [2] = '{"+IPD,19:verification:passed",
                            "+IPD,19:verification:failed"};

    // line tracker state
    link_state_t lnk_state;
    int          line_len;
    int          kw_prog [NUM_KEYS];
    bit          kw_hit  [NUM_KEYS];
    bit          pfx_ok  [2];

    line_report_t reports_due[$];
    logic [7:0]   line_buf[$];

    bit  calm = 1'b0;
    int  n_err, n_bytes, n_lines, n_changes, n_wraps, n_passed, n_failed, cycles;
    bit  [4:0] states_hit;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 38);
    end

    function automatic void restart_line();
        line_len = 0;
        foreach (kw_prog[k]) begin
            kw_prog[k] = 0;
            kw_hit[k]  = 1'b0;
        end
        pfx_ok[0] = 1'b1;
        pfx_ok[1] = 1'b1;
    endfunction

    // longest keyword head (at most cap chars) ending the first p chars followed by c
    function automatic int match_extend(string kw, int p, logic [7:0] c, int cap);
        int  k;
        int  start;
        bit  ok;
        k = (p + 1 < cap) ? p + 1 : cap;
        while (k > 0) begin
            start = p + 1 - k;
            ok = 1'b1;
            for (int i = 0; i < k; i++) begin
                if (kw[i] != ((start + i < p) ? kw[start + i] : c)) ok = 1'b0;
            end
            if (ok) return k;
            k--;
        end
        return 0;
    endfunction

    function automatic void track_byte(logic [7:0] b);
        link_state_t nxt;
        verdict_t    vd;
        int          klen;
        int          p;
        int          n;
        if (b == CH_NL) begin
            nxt = lnk_state;
            if (kw_hit[K_WIFI]) begin
                if (kw_hit[K_DISC]) nxt = LS_DISCONNECTED;
                else if (kw_hit[K_CONN]) nxt = LS_JOINED;
                else if (kw_hit[K_GOTIP]) nxt = LS_HAS_ADDR;
            end else if (kw_hit[K_ALREADY] || kw_hit[K_CONNECT]) begin
                nxt = LS_SERVER;
            end else if (kw_hit[K_CLOSED]) begin
                nxt = LS_HAS_ADDR;
            end else if (kw_hit[K_SENDOK]) begin
                nxt = LS_DATA_SENT;
            end
            vd = VD_NONE;
            if (line_len >= PFX_CHARS) begin
                if (pfx_ok[0]) vd = VD_PASSED;
                else if (pfx_ok[1]) vd = VD_FAILED;
            end
            reports_due.push_back('{nxt, nxt != lnk_state, vd, line_len[7:0]});
            n_lines++;
            if (nxt != lnk_state) n_changes++;
            if (vd == VD_PASSED) n_passed++;
            if (vd == VD_FAILED) n_failed++;
            states_hit[nxt] = 1'b1;
            lnk_state = nxt;
            restart_line();
        end else if (b != CH_CR) begin
            for (int j = 0; j < 2; j++) begin
                if (line_len < PFX_CHARS && pfx_text[j][line_len] != b) pfx_ok[j] = 1'b0;
            end
            for (int k = 0; k < NUM_KEYS; k++) begin
                klen = kw_text[k].len();
                p = (kw_prog[k] >= klen) ? 0 : kw_prog[k];
                n = match_extend(kw_text[k], p, b, klen);
                if (n == klen) begin
                    kw_hit[k] = 1'b1;
                    n = match_extend(kw_text[k], p, b, klen - 1);
                end
                kw_prog[k] = n;
            end
            line_len++;
            if (line_len >= LINE_MAX) begin
                restart_line();
                n_wraps++;
            end
        end
    endfunction

    function automatic void check_field(string what, int want, int got);
        if (want != got) begin
            n_err++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        line_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (reports_due.size() == 0) begin
                n_err++;
                $display("%0t: unexpected transfer, expected none, actual %h", $time, m_tdata);
            end else begin
                want = reports_due.pop_front();
                check_field("link_state", want.state, m_tdata[2:0]);
                check_field("state_changed", want.changed, m_tdata[3]);
                check_field("verdict", want.verdict, m_tdata[5:4]);
                check_field("line_length", want.length, m_tdata[13:6]);
                check_field("pad bits", 0, m_tdata[15:14]);
            end
        end
    end

    task automatic send_byte(logic [7:0] b);
        while (!calm && $urandom_range(99) < 38) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        track_byte(b);
        n_bytes++;
    endtask

    function automatic void put_byte(logic [7:0] b);
        line_buf.push_back(b);
    endfunction

    function automatic void put_text(string t);
        for (int i = 0; i < t.len(); i++) line_buf.push_back(t[i]);
    endfunction

    task automatic send_buf();
        while (line_buf.size() != 0) send_byte(line_buf.pop_front());
    endtask

    // hold the sender off until every line report is back
    task automatic wait_replies();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (reports_due.size() != 0) @(posedge aclk);
    endtask

    task automatic test_link_keywords();
        put_text("WIFI CONNECTED\r\n");
        put_text("WIFI GOT IP\r\n");
        put_text("ALREADY CONNECTED\r\n");
        put_text("SEND OK\r\n");
        put_text("CLOSED\n");
        put_text("CONNECCONNECT\n");
        put_text("WIFI DISCONNECTED\n");
        put_text("WIFI \n");
        put_text("\n");
        send_buf();
    endtask

    task automatic test_verdicts();
        put_text("+IPD,19:verification:passed\r\n");
        put_text("+IPD,19:verification:failed, retry\n");
        put_text("+IPD,19:verification:passe\n");   // one char short
        put_text("+IPD,19:verification:passXd\n");
        put_byte(8'h00);
        put_byte(8'hFF);
        put_text("SEND OK\n");
        send_buf();
    endtask

    task automatic test_line_wrap();
        // keyword lands before the wrap and must be forgotten
        put_text("SEND OK");
        repeat (LINE_MAX - 7) put_byte("x");
        put_text("ab\n");
        repeat (LINE_MAX - 1) put_byte("y");
        put_byte(CH_NL);
        send_buf();
    endtask

    task automatic build_random_line();
        string alpha;
        int    r;
        int    n;
        int    base;
        alpha = "CONNECTEDISWFGOTPALRYSK +,:19";
        r = $urandom_range(99);
        if (r < 12) begin
            n = $urandom_range(16);
            repeat (n) put_byte(8'($urandom_range(255)));
        end else if (r < 45) begin
            repeat ($urandom_range(3)) put_byte(8'($urandom_range(32, 126)));
            if ($urandom_range(1)) put_text("WIFI ");
            put_text(kw_text[$urandom_range(NUM_KEYS - 1)]);
            if ($urandom_range(3) == 0) put_text(kw_text[$urandom_range(NUM_KEYS - 1)]);
            repeat ($urandom_range(3)) put_byte(8'($urandom_range(32, 126)));
        end else if (r < 62) begin
            base = line_buf.size();
            put_text(pfx_text[$urandom_range(1)]);
            if ($urandom_range(1))
                line_buf[base + $urandom_range(PFX_CHARS - 1)] = 8'($urandom_range(32, 126));
            if ($urandom_range(1)) put_text(" ok");
        end else if (r < 85) begin
            n = $urandom_range(3, 30);
            repeat (n) put_byte(alpha[$urandom_range(alpha.len() - 1)]);
        end else if (r < 97) begin
            put_text(pfx_text[$urandom_range(1)].substr(0, $urandom_range(PFX_CHARS - 1)));
        end else begin
            n = $urandom_range(LINE_MAX - 8, LINE_MAX + 40);
            repeat (n) put_byte(alpha[$urandom_range(alpha.len() - 1)]);
        end
        if ($urandom_range(1)) put_byte(CH_CR);
        put_byte(CH_NL);
    endtask

    task automatic test_random_traffic();
        int  start;
        int  done;
        bit  drained;
        start   = n_bytes;
        drained = 1'b0;
        done    = 0;
        while (done < RANDOM_BYTES) begin
            calm = (done >= 300 && done < 550);
            if (!drained && done >= 700) begin
                wait_replies();
                drained = 1'b1;
            end
            build_random_line();
            send_buf();
            done = n_bytes - start;
        end
        calm = 1'b0;
    endtask

    initial begin
        lnk_state  = LS_DISCONNECTED;
        states_hit = '0;
        restart_line();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_link_keywords();
        test_verdicts();
        test_line_wrap();
        test_random_traffic();
        wait_replies();
        repeat (20) @(posedge aclk);
        $display("Fed %0d bytes forming %0d lines: %0d link state changes, %0d wraps.",
                 n_bytes, n_lines, n_changes, n_wraps);
        $display("Verdicts passed %0d, failed %0d; link states reached mask %b.",
                 n_passed, n_failed, states_hit);
        if (n_err == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
